// ===== hdl/tsfa_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tsfa_pkg: shared types and constants of the temperature spike filter
// Field widths, special codes and the control word handed to the row of
// window cells.
// ---------------------------------------------------------------------------
package tsfa_pkg;

  // Field widths
  localparam int READING_W = 12;
  localparam int TEMP_W    = 14;
  localparam int ERR_W     = 16;
  localparam int JUMP_W    = 8;
  localparam int RETRY_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // Only positive readings reach the window, so a slot needs no sign bit
  localparam int SLOT_W = READING_W - 1;

  // Special values, sixteenths of a degree
  localparam logic signed [READING_W-1:0] DISCONNECT_CODE = -12'sd2032;
  localparam logic signed [TEMP_W-1:0]    FAILED_TEMP     = -14'sd4368;

  // Register reset values
  localparam logic [JUMP_W-1:0]  JUMP_RESET  = 8'd80;
  localparam logic [RETRY_W-1:0] RETRY_RESET = 4'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JUMP_LIMIT  = 2'd0,
    CFG_RETRY_LIMIT = 2'd1
  } cfg_idx_e;

  // Control word for the window cells
  typedef struct packed {
    logic shift;  // take the left neighbour's slot
    logic fill;   // load the new reading into every slot
  } cell_ctl_t;

  // One result word
  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic                     rejected;
    logic                     sensor_failed;
    logic [ERR_W-1:0]         total_errors;
  } res_t;

endpackage
`default_nettype wire

// ===== hdl/tsfa_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tsfa_if: handshake channels of the temperature spike filter
// Reading input, result output and configuration write channels, each with
// valid, ready and payload.
// ---------------------------------------------------------------------------
interface tsfa_in_if;
  logic                    valid;
  logic                    ready;
  logic signed [11:0]      reading;

  modport source (output valid, output reading, input ready);
  modport sink   (input valid, input reading, output ready);
endinterface

interface tsfa_out_if;
  logic                    valid;
  logic                    ready;
  logic signed [13:0]      temperature;
  logic                    rejected;
  logic                    sensor_failed;
  logic [15:0]             total_errors;

  modport source (output valid, output temperature, output rejected,
                  output sensor_failed, output total_errors, input ready);
  modport sink   (input valid, input temperature, input rejected,
                  input sensor_failed, input total_errors, output ready);
endinterface

interface tsfa_cfg_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              index;
  logic [7:0]              data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/tsfa_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tsfa_cell: one slot of the averaging window
// Holds one reading; loads the new reading on a fill, or takes the slot of
// its left neighbour on a shift.
// ---------------------------------------------------------------------------
module tsfa_cell
  import tsfa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire cell_ctl_t         ctl_i,
  input  wire logic [SLOT_W-1:0] fill_i,
  input  wire logic [SLOT_W-1:0] left_i,
  output logic      [SLOT_W-1:0] slot_o
);

  logic [SLOT_W-1:0] slot_q, slot_d;

  // Choose fill, shift or hold
  always_comb begin
    slot_d = slot_q;
    if (ctl_i.fill) begin
      slot_d = fill_i;
    end else if (ctl_i.shift) begin
      slot_d = left_i;
    end
  end

  // Slot register, undefined until first written
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule
`default_nettype wire

// ===== hdl/tsfa_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tsfa_div: window sum divided by the window length
// Multiplies by a rounded-up reciprocal with enough fraction bits that the
// truncated quotient is exact over the whole sum range.
// ---------------------------------------------------------------------------
module tsfa_div
  import tsfa_pkg::*;
#(
  parameter int WINDOW = 5
) (
  input  wire logic [SLOT_W+$clog2(WINDOW)-1:0] sum_i,
  output logic      [SLOT_W-1:0]                quot_o
);

  localparam int SUM_W  = SLOT_W + $clog2(WINDOW);
  localparam int SHIFT  = SUM_W + $clog2(WINDOW);
  localparam int MULT_I = ((1 << SHIFT) + WINDOW - 1) / WINDOW;
  localparam logic [SUM_W:0] MULT = (SUM_W+1)'(MULT_I);

  logic [2*SUM_W:0] prod;

  // Scale by the reciprocal and drop the fraction bits
  assign prod   = (2*SUM_W+1)'(sum_i) * (2*SUM_W+1)'(MULT);
  assign quot_o = prod[SHIFT +: SLOT_W];

endmodule
`default_nettype wire

// ===== hdl/temperature_spike_filter_average_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// temperature_spike_filter_average_top: spike-rejecting moving average
// Filters signed temperature readings through a window of WINDOW readings,
// rejecting disconnect codes and jumps beyond the configured limit.
// ---------------------------------------------------------------------------
// Usage:
//   reading_i  - one raw reading per word (signed sixteenths of a degree).
//   result_o   - one result word per reading: filtered temperature, reject
//                flag, sticky failure flag and saturating error total.
//   cfg_i      - register writes, index 0 jump limit, index 1 retry limit;
//                always ready, write only while the block is idle.
// Output: the result of an accepted reading is registered in the output buffer.
// Throughput: one reading per cycle while the output buffer is not full; the
//   average of one reading is ready for the spike check of the next, computed
//   in the same cycle from a running sum and a reciprocal multiply.
// Reset: clears the average, the failure flag and the error total, reloads
//   retries with 3 and the limits with 80 and 3; window slots are not reset.
// Stall: a two-word output buffer keeps taking readings while one result
//   waits; reading_i.ready falls only when both words are held.
// ---------------------------------------------------------------------------
module temperature_spike_filter_average_top
  import tsfa_pkg::*;
#(
  parameter int WINDOW = 5
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  tsfa_in_if.sink       reading_i,
  tsfa_out_if.source    result_o,
  tsfa_cfg_if.sink      cfg_i
);

  localparam int SUM_W = SLOT_W + $clog2(WINDOW);

  // Configuration registers
  logic [JUMP_W-1:0]  jump_q;
  logic [RETRY_W-1:0] retry_q;

  // Filter state
  logic signed [TEMP_W-1:0] cur_q, cur_d;
  logic                     primed_q, primed_d;
  logic                     filled_q, filled_d;
  logic [RETRY_W-1:0]       retries_q, retries_d;
  logic [ERR_W-1:0]         err_q, err_d;
  logic                     failed_q, failed_d;
  logic [SUM_W-1:0]         sum_q, sum_d;

  // Output buffer
  logic [1:0] cnt_q, cnt_d;
  res_t       e0_q, e0_d, e1_q, e1_d;
  res_t       res;

  logic push, pop;

  // Step datapath
  logic signed [READING_W-1:0] r;
  logic [SLOT_W-1:0]           r_slot;
  logic signed [TEMP_W:0]      diff;
  logic [TEMP_W:0]             abs_diff;
  logic                        rej;
  logic                        take;
  logic [SUM_W:0]              sum_run;
  logic [SLOT_W-1:0]           quot;
  cell_ctl_t                   ctl;
  logic [SLOT_W-1:0]           slot [WINDOW];

  assign push = reading_i.valid && reading_i.ready;
  assign pop  = result_o.valid && result_o.ready;

  assign r      = reading_i.reading;
  assign r_slot = r[SLOT_W-1:0];

  // Compare against the current average
  assign diff     = {cur_q[TEMP_W-1], cur_q} - (TEMP_W+1)'(r);
  assign abs_diff = diff[TEMP_W] ? (TEMP_W+1)'(-diff) : (TEMP_W+1)'(diff);
  assign rej      = primed_q && ((r == DISCONNECT_CODE) ||
                                 (abs_diff > (TEMP_W+1)'(jump_q)));
  assign take     = primed_q && !rej && (r > 12'sd0);

  // Running sum: add the new reading, drop the oldest
  assign sum_run = (SUM_W+1)'(sum_q) + (SUM_W+1)'(r_slot)
                 - (SUM_W+1)'(slot[WINDOW-1]);

  tsfa_div #(.WINDOW(WINDOW)) u_div (
    .sum_i  (sum_run[SUM_W-1:0]),
    .quot_o (quot)
  );

  // Window row control
  assign ctl.fill  = push && take && !filled_q;
  assign ctl.shift = push && take && filled_q;

  // Row of window cells, new reading enters on the left
  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    if (g == 0) begin : g_head
      tsfa_cell u_cell (
        .clk_i  (clk_i),
        .ctl_i  (ctl),
        .fill_i (r_slot),
        .left_i (r_slot),
        .slot_o (slot[g])
      );
    end else begin : g_body
      tsfa_cell u_cell (
        .clk_i  (clk_i),
        .ctl_i  (ctl),
        .fill_i (r_slot),
        .left_i (slot[g-1]),
        .slot_o (slot[g])
      );
    end
  end

  // Next filter state and result word
  always_comb begin
    cur_d     = cur_q;
    primed_d  = primed_q;
    filled_d  = filled_q;
    retries_d = retries_q;
    err_d     = err_q;
    sum_d     = sum_q;
    if (!primed_q) begin
      cur_d    = TEMP_W'(r);
      primed_d = 1'b1;
    end else if (rej) begin
      if (retries_q != '0) begin
        retries_d = retries_q - 1'b1;
      end
      if (err_q != '1) begin
        err_d = err_q + 1'b1;
      end
    end else if (take) begin
      retries_d = retry_q;
      filled_d  = 1'b1;
      if (filled_q) begin
        sum_d = sum_run[SUM_W-1:0];
        cur_d = TEMP_W'(quot);
      end else begin
        sum_d = SUM_W'(r_slot) * SUM_W'(WINDOW);
        cur_d = TEMP_W'(r);
      end
    end
    failed_d = failed_q || (retries_d == '0);
    if (failed_d) begin
      cur_d = FAILED_TEMP;
    end
    res.temperature   = cur_d;
    res.rejected      = rej;
    res.sensor_failed = failed_d;
    res.total_errors  = err_d;
  end

  // Filter state registers, advance on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      primed_q  <= 1'b0;
      filled_q  <= 1'b0;
      retries_q <= RETRY_RESET;
      err_q     <= '0;
      failed_q  <= 1'b0;
      sum_q     <= '0;
    end else if (push) begin
      cur_q     <= cur_d;
      primed_q  <= primed_d;
      filled_q  <= filled_d;
      retries_q <= retries_d;
      err_q     <= err_d;
      failed_q  <= failed_d;
      sum_q     <= sum_d;
    end
  end

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_q  <= JUMP_RESET;
      retry_q <= RETRY_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_JUMP_LIMIT:  jump_q  <= cfg_i.data[JUMP_W-1:0];
        CFG_RETRY_LIMIT: retry_q <= cfg_i.data[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  // Two-word output buffer: head word e0, second word e1
  always_comb begin
    cnt_d = cnt_q;
    e0_d  = e0_q;
    e1_d  = e1_q;
    case (cnt_q)
      2'd0: begin
        if (push) begin
          e0_d  = res;
          cnt_d = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          e0_d = res;
        end else if (push) begin
          e1_d  = res;
          cnt_d = 2'd2;
        end else if (pop) begin
          cnt_d = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          e0_d  = e1_q;
          cnt_d = 2'd1;
        end
      end
      default: cnt_d = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Buffered words carry no reset
  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

  assign reading_i.ready      = (cnt_q != 2'd2);
  assign result_o.valid       = (cnt_q != 2'd0);
  assign result_o.temperature   = e0_q.temperature;
  assign result_o.rejected      = e0_q.rejected;
  assign result_o.sensor_failed = e0_q.sensor_failed;
  assign result_o.total_errors  = e0_q.total_errors;

endmodule
`default_nettype wire
